// ===== rtl/topk_quality_buffer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files of the top-k quality buffer.
// Both expect signals named clock and reset in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef TOPK_QUALITY_BUFFER_UNIT_MACROS_SVH
`define TOPK_QUALITY_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TQB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TQB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tqb_pkg.sv =====
// ---------------------------------------------------------------------------
// tqb_pkg
// Types, widths and codes shared by the top-k quality buffer modules.
// ---------------------------------------------------------------------------
package tqb_pkg;

   // Field widths
   localparam int TAG_W    = 32;
   localparam int DIM_W    = 12;
   localparam int QUAL_W   = 24;
   localparam int CNT_W    = 32;
   localparam int TARGET_W = 3;
   // Width holding 2*target+2
   localparam int CAP_W    = 5;

   localparam int DEPTH_DEFAULT = 16;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 3'd1;

   // Insert status codes
   localparam logic [1:0] ST_APPENDED    = 2'd0;
   localparam logic [1:0] ST_REPLACED    = 2'd1;
   localparam logic [1:0] ST_DROPPED     = 2'd2;
   localparam logic [1:0] ST_NOT_RECEIVE = 2'd3;

   // Opcodes
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [TAG_W-1:0]  record_tag;
      logic [DIM_W-1:0]  box_width;
      logic [DIM_W-1:0]  box_height;
   } req_type;

   typedef struct packed {
      logic [1:0]        insert_status;
      logic              chosen_valid;
      logic [TAG_W-1:0]  chosen_tag;
      logic [QUAL_W-1:0] chosen_quality;
      logic              done_res;
      logic [CNT_W-1:0]  received_total;
      logic [CNT_W-1:0]  chosen_total;
   } rsp_type;

   // Scan token passed from cell to cell (index travels beside it)
   typedef struct packed {
      logic              go;
      logic              have;
      logic              find_max;
      logic [QUAL_W-1:0] quality;
      logic [TAG_W-1:0]  tag;
   } token_type;

   // Update controls broadcast to every cell
   typedef struct packed {
      logic              wr_en;
      logic              shift_en;
      logic [TAG_W-1:0]  wr_tag;
      logic [QUAL_W-1:0] wr_quality;
   } cell_ctl_type;

endpackage

// ===== rtl/tqb_cell.sv =====
// ---------------------------------------------------------------------------
// tqb_cell
// One buffer slot: holds a record and advances the min/max scan token by one
// slot per cycle. Also takes a write or a left shift from its right neighbor.
// ---------------------------------------------------------------------------
module tqb_cell #(
   parameter int IDX    = 0,
   parameter int IDX_W  = 4,
   parameter int FILL_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tqb_pkg::cell_ctl_type      ctl,
   input  logic [IDX_W-1:0]           wr_idx,
   input  logic [IDX_W-1:0]           shift_idx,
   input  logic [FILL_W-1:0]          fill,
   input  tqb_pkg::token_type         tok_i,
   input  logic [IDX_W-1:0]           tok_idx_i,
   output tqb_pkg::token_type         tok_o,
   output logic [IDX_W-1:0]           tok_idx_o,
   input  logic [tqb_pkg::TAG_W-1:0]  next_tag,
   input  logic [tqb_pkg::QUAL_W-1:0] next_quality,
   output logic [tqb_pkg::TAG_W-1:0]  tag_o,
   output logic [tqb_pkg::QUAL_W-1:0] quality_o
);

   localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(IDX);
   localparam logic [FILL_W-1:0] MY_FILL = FILL_W'(IDX);

   logic [tqb_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [tqb_pkg::QUAL_W-1:0] qual_ff, qual_in;
   tqb_pkg::token_type         tok_ff, tok_in;
   logic [IDX_W-1:0]           tidx_ff, tidx_in;
   logic                       occupied;
   logic                       better;
   logic                       take_own;

   // Scan step: first strict extreme among occupied slots
   always_comb begin
      occupied = MY_FILL < fill;
      better   = tok_i.find_max ? (qual_ff > tok_i.quality) : (qual_ff < tok_i.quality);
      take_own = occupied && (!tok_i.have || better);
      tok_in          = tok_i;
      tok_in.have     = tok_i.have | occupied;
      tidx_in         = tok_idx_i;
      if (take_own) begin
         tok_in.quality = qual_ff;
         tok_in.tag     = tag_ff;
         tidx_in        = MY_IDX;
      end
   end

   // Slot update: direct write or close the gap from the right
   always_comb begin
      tag_in  = tag_ff;
      qual_in = qual_ff;
      if (ctl.wr_en && (wr_idx == MY_IDX)) begin
         tag_in  = ctl.wr_tag;
         qual_in = ctl.wr_quality;
      end else if (ctl.shift_en && (MY_IDX >= shift_idx)) begin
         tag_in  = next_tag;
         qual_in = next_quality;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.go <= 1'b0;
      end else begin
         tok_ff.go <= tok_in.go;
      end
      tok_ff.have     <= tok_in.have;
      tok_ff.find_max <= tok_in.find_max;
      tok_ff.quality  <= tok_in.quality;
      tok_ff.tag      <= tok_in.tag;
      tidx_ff         <= tidx_in;
      tag_ff          <= tag_in;
      qual_ff         <= qual_in;
   end

   assign tok_o     = tok_ff;
   assign tok_idx_o = tidx_ff;
   assign tag_o     = tag_ff;
   assign quality_o = qual_ff;

endmodule

// ===== rtl/topk_quality_buffer_unit.sv =====
// ---------------------------------------------------------------------------
// topk_quality_buffer_unit
// Bounded top-k buffer of candidate records ranked by width times height.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (valid/stall): a receive transaction offers a record; an
//   extract transaction removes the best record. rsp channel (valid/stall)
//   returns one result per request with status, chosen record, done flag and
//   the receive and extract totals. csr channel (valid/ready, ready outside
//   reset) writes target_count; capacity is 2*target_count+2, clamped to DEPTH.
// Timing:
//   One request at a time: the scan token crosses the chain of DEPTH
//   cells one cell per cycle, S_SCAN latches the winner, and S_FINISH
//   applies the update and loads the result register.
//   A request is taken while a finished result still waits in rsp; its own
//   result waits in S_FINISH until that register is free.
// Reset:
//   Buffer empty, both totals zero, target_count 1. req_stall is high and
//   csr_ready low during reset. Stored records are not cleared; only slots
//   below the fill level are ever used.
// Stall:
//   rsp payload holds while rsp_stall is high; req_stall stays high until the
//   pending result has been handed to the rsp register.
// ---------------------------------------------------------------------------
module topk_quality_buffer_unit #(
   parameter int DEPTH = tqb_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tqb_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tqb_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tqb_pkg::TARGET_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (FILL_W > tqb_pkg::CAP_W) ? FILL_W : tqb_pkg::CAP_W;
   localparam int QW     = tqb_pkg::QUAL_W;
   localparam int CW     = tqb_pkg::CNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [CW-1:0]                rcnt_ff, rcnt_in;
   logic [CW-1:0]                ccnt_ff, ccnt_in;
   logic [tqb_pkg::TARGET_W-1:0] target_ff, target_in;
   logic                         op_ff, op_in;
   logic [tqb_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic [QW-1:0]                qual_ff, qual_in;
   logic                         best_have_ff, best_have_in;
   logic [QW-1:0]                best_q_ff, best_q_in;
   logic [tqb_pkg::TAG_W-1:0]    best_tag_ff, best_tag_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tqb_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         accept;
   logic                         fire;
   logic                         out_free;
   logic [tqb_pkg::CAP_W-1:0]    cap_raw;
   logic [CMP_W-1:0]             cap;
   logic                         can_append;
   tqb_pkg::cell_ctl_type        ctl;
   logic [IDX_W-1:0]             wr_idx;
   logic [IDX_W-1:0]             shift_idx;

   tqb_pkg::token_type           tok   [DEPTH+1];
   logic [IDX_W-1:0]             tidx  [DEPTH+1];
   logic [tqb_pkg::TAG_W-1:0]    ctag  [DEPTH];
   logic [QW-1:0]                cqual [DEPTH];

   // Handshakes
   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == S_FINISH) && out_free;
   assign csr_ready = !reset;

   // Capacity 2*target+2 clamped to DEPTH
   assign cap_raw    = {1'b0, target_ff, 1'b0} + tqb_pkg::CAP_W'(2);
   assign cap        = (CMP_W'(cap_raw) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_raw);
   assign can_append = CMP_W'(fill_ff) < cap;

   // Scan token entering the chain
   always_comb begin
      tok[0].go       = accept;
      tok[0].have     = 1'b0;
      tok[0].find_max = req_data.opcode;
      tok[0].quality  = '0;
      tok[0].tag      = '0;
      tidx[0]         = '0;
   end

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [tqb_pkg::TAG_W-1:0] nt;
      logic [QW-1:0]             nq;
      if (i == DEPTH - 1) begin : g_last
         assign nt = ctag[i];
         assign nq = cqual[i];
      end else begin : g_mid
         assign nt = ctag[i+1];
         assign nq = cqual[i+1];
      end
      tqb_cell #(
         .IDX    (i),
         .IDX_W  (IDX_W),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .wr_idx       (wr_idx),
         .shift_idx    (shift_idx),
         .fill         (fill_ff),
         .tok_i        (tok[i]),
         .tok_idx_i    (tidx[i]),
         .tok_o        (tok[i+1]),
         .tok_idx_o    (tidx[i+1]),
         .next_tag     (nt),
         .next_quality (nq),
         .tag_o        (ctag[i]),
         .quality_o    (cqual[i])
      );
   end

   // Sequencer, update decision and result
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rcnt_in      = rcnt_ff;
      ccnt_in      = ccnt_ff;
      target_in    = csr_valid ? csr_data : target_ff;
      op_in        = op_ff;
      tag_in       = tag_ff;
      qual_in      = qual_ff;
      best_have_in = best_have_ff;
      best_q_in    = best_q_ff;
      best_tag_in  = best_tag_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.wr_en      = 1'b0;
      ctl.shift_en   = 1'b0;
      ctl.wr_tag     = tag_ff;
      ctl.wr_quality = qual_ff;
      wr_idx         = best_idx_ff;
      shift_idx      = best_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_data.opcode;
               tag_in   = req_data.record_tag;
               qual_in  = QW'(req_data.box_width) * QW'(req_data.box_height);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok[DEPTH].go) begin
               best_have_in = tok[DEPTH].have;
               best_q_in    = tok[DEPTH].quality;
               best_tag_in  = tok[DEPTH].tag;
               best_idx_in  = tidx[DEPTH];
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (fire) begin
               rsp_in.insert_status  = tqb_pkg::ST_NOT_RECEIVE;
               rsp_in.chosen_valid   = 1'b0;
               rsp_in.chosen_tag     = '0;
               rsp_in.chosen_quality = '0;
               if (op_ff == tqb_pkg::OP_RECEIVE) begin
                  rcnt_in = rcnt_ff + CW'(1);
                  if (can_append) begin
                     ctl.wr_en            = 1'b1;
                     wr_idx               = IDX_W'(fill_ff);
                     fill_in              = fill_ff + FILL_W'(1);
                     rsp_in.insert_status = tqb_pkg::ST_APPENDED;
                  end else if (fill_ff == '0 || !best_have_ff) begin
                     rsp_in.insert_status = tqb_pkg::ST_DROPPED;
                  end else if (qual_ff > best_q_ff) begin
                     ctl.wr_en            = 1'b1;
                     rsp_in.insert_status = tqb_pkg::ST_REPLACED;
                  end else begin
                     rsp_in.insert_status = tqb_pkg::ST_DROPPED;
                  end
               end else if (fill_ff != '0) begin
                  ctl.shift_en          = 1'b1;
                  fill_in               = fill_ff - FILL_W'(1);
                  ccnt_in               = ccnt_ff + CW'(1);
                  rsp_in.chosen_valid   = 1'b1;
                  rsp_in.chosen_tag     = best_tag_ff;
                  rsp_in.chosen_quality = best_q_ff;
               end
               rsp_in.done_res       = (fill_in == '0) || (ccnt_in >= CW'(target_ff));
               rsp_in.received_total = rcnt_in;
               rsp_in.chosen_total   = ccnt_in;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rcnt_ff      <= '0;
         ccnt_ff      <= '0;
         target_ff    <= tqb_pkg::TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rcnt_ff      <= rcnt_in;
         ccnt_ff      <= ccnt_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      qual_ff      <= qual_in;
      best_have_ff <= best_have_in;
      best_q_ff    <= best_q_in;
      best_tag_ff  <= best_tag_in;
      best_idx_ff  <= best_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/tqb_checker.sv =====
// ---------------------------------------------------------------------------
// tqb_checker
// Port-level checks on the top-k quality buffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "topk_quality_buffer_unit_macros.svh"

module tqb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tqb_pkg::rsp_type rsp_data
);

   // Held result stays offered
   `TQB_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // Held result does not change
   `TQB_ASSERT_NXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data),
                   "rsp changed while stalled")

   // Only an extract returns a record
   `TQB_ASSERT_IMP(a_chosen_status, rsp_valid && rsp_data.chosen_valid,
                   rsp_data.insert_status == tqb_pkg::ST_NOT_RECEIVE,
                   "chosen record on a receive")

   // No record means zero tag and quality
   `TQB_ASSERT_IMP(a_chosen_zero, rsp_valid && !rsp_data.chosen_valid,
                   rsp_data.chosen_tag == '0 && rsp_data.chosen_quality == '0,
                   "nonzero record without chosen_valid")

endmodule

bind topk_quality_buffer_unit tqb_checker u_tqb_checker (.*);
